>>> hdl/qalu_pkg.sv
package qalu_pkg;

    // Arithmetic format
    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int FIELD_BITS    = 32;
    localparam int OPND_BITS     = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
    localparam int PROD_BITS     = 2 * FIELD_BITS;
    localparam int ACC_BITS      = PROD_BITS + 2;
    localparam int LANES         = 4;
    localparam int TERMS         = 4;
    localparam int OP_BITS       = 3;

    // Lane order: x, y, z, then the real part w
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_W = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_SCALE = 3'd3,
        OP_NEG   = 3'd4,
        OP_CONJ  = 3'd5,
        OP_DOT   = 3'd6
    } t_op;

    typedef logic signed [FIELD_BITS-1:0] t_word;
    typedef logic signed [PROD_BITS-1:0]  t_term;

    // Input item
    typedef struct packed {
        logic [OP_BITS-1:0] operation;
        t_word              a_x;
        t_word              a_y;
        t_word              a_z;
        t_word              a_w;
        t_word              b_x;
        t_word              b_y;
        t_word              b_z;
        t_word              b_w;
        t_word              scalar_in;
    } t_in;

    // Result item
    typedef struct packed {
        t_word r_x;
        t_word r_y;
        t_word r_z;
        t_word r_w;
        t_word scalar_out;
        logic  overflow;
    } t_out;

    // Partial terms between the multiply and the sum stage
    typedef struct packed {
        logic [OP_BITS-1:0]                  op;
        logic                                scaled;
        t_term [LANES-1:0][TERMS-1:0]        term;
    } t_terms;

    // Operand: low OPND_BITS of the field, sign-extended
    function automatic t_word opnd(input t_word v);
        t_word sh;
        sh = v <<< (FIELD_BITS - OPND_BITS);
        return sh >>> (FIELD_BITS - OPND_BITS);
    endfunction

    // Exact signed widening
    function automatic t_term widen(input t_word v);
        return PROD_BITS'(v);
    endfunction

endpackage

>>> hdl/qalu_mul_stage.sv
module qalu_mul_stage import qalu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_in    i_data,
    output logic   o_ready,
    output logic   o_valid,
    input  logic   i_ready,
    output t_terms o_terms
);

    t_word             a [LANES];
    t_word             b [LANES];
    t_word             s;
    t_word             mx [LANES][TERMS];
    t_word             my [LANES][TERMS];
    logic [TERMS-1:0]  negm [LANES];
    t_term             prod [LANES][TERMS];
    t_terms            n_terms;
    logic              r_valid;
    t_terms            r_terms;
    logic              load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // Operand unpack
    always_comb begin
        a[LANE_X] = opnd(i_data.a_x);
        a[LANE_Y] = opnd(i_data.a_y);
        a[LANE_Z] = opnd(i_data.a_z);
        a[LANE_W] = opnd(i_data.a_w);
        b[LANE_X] = opnd(i_data.b_x);
        b[LANE_Y] = opnd(i_data.b_y);
        b[LANE_Z] = opnd(i_data.b_z);
        b[LANE_W] = opnd(i_data.b_w);
        s         = opnd(i_data.scalar_in);
    end

    // Multiplier operand select, one 4x4 array shared by product, scale and dot
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            negm[l] = '0;
            for (int k = 0; k < TERMS; k++) begin
                mx[l][k] = '0;
                my[l][k] = '0;
            end
        end
        case (i_data.operation)
            OP_MUL: begin
                mx[LANE_X] = '{a[LANE_W], a[LANE_X], a[LANE_Y], a[LANE_Z]};
                my[LANE_X] = '{b[LANE_X], b[LANE_W], b[LANE_Z], b[LANE_Y]};
                mx[LANE_Y] = '{a[LANE_W], a[LANE_Y], a[LANE_Z], a[LANE_X]};
                my[LANE_Y] = '{b[LANE_Y], b[LANE_W], b[LANE_X], b[LANE_Z]};
                mx[LANE_Z] = '{a[LANE_W], a[LANE_Z], a[LANE_X], a[LANE_Y]};
                my[LANE_Z] = '{b[LANE_Z], b[LANE_W], b[LANE_Y], b[LANE_X]};
                mx[LANE_W] = '{a[LANE_W], a[LANE_X], a[LANE_Y], a[LANE_Z]};
                my[LANE_W] = '{b[LANE_W], b[LANE_X], b[LANE_Y], b[LANE_Z]};
                // cross term is subtracted in x, y, z; w subtracts the vector dot
                negm[LANE_X] = 4'b1000;
                negm[LANE_Y] = 4'b1000;
                negm[LANE_Z] = 4'b1000;
                negm[LANE_W] = 4'b1110;
            end
            OP_SCALE: begin
                for (int l = 0; l < LANES; l++) begin
                    mx[l][0] = a[l];
                    my[l][0] = s;
                end
            end
            OP_DOT: begin
                for (int k = 0; k < TERMS; k++) begin
                    mx[LANE_W][k] = a[k];
                    my[LANE_W][k] = b[k];
                end
            end
            default: begin
            end
        endcase
    end

    // Multiplier array
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            for (int k = 0; k < TERMS; k++) begin
                prod[l][k] = widen(mx[l][k]) * widen(my[l][k]);
            end
        end
    end

    // Term select per operation
    always_comb begin
        n_terms.op     = i_data.operation;
        n_terms.scaled = 1'b0;
        n_terms.term   = '0;
        case (i_data.operation)
            OP_ADD: begin
                for (int l = 0; l < LANES; l++) begin
                    n_terms.term[l][0] = widen(a[l]);
                    n_terms.term[l][1] = widen(b[l]);
                end
            end
            OP_SUB: begin
                for (int l = 0; l < LANES; l++) begin
                    n_terms.term[l][0] = widen(a[l]);
                    n_terms.term[l][1] = -widen(b[l]);
                end
            end
            OP_NEG: begin
                for (int l = 0; l < LANES; l++) begin
                    n_terms.term[l][0] = -widen(a[l]);
                end
            end
            OP_CONJ: begin
                n_terms.term[LANE_X][0] = -widen(a[LANE_X]);
                n_terms.term[LANE_Y][0] = -widen(a[LANE_Y]);
                n_terms.term[LANE_Z][0] = -widen(a[LANE_Z]);
                n_terms.term[LANE_W][0] = widen(a[LANE_W]);
            end
            OP_MUL, OP_SCALE, OP_DOT: begin
                n_terms.scaled = 1'b1;
                for (int l = 0; l < LANES; l++) begin
                    for (int k = 0; k < TERMS; k++) begin
                        n_terms.term[l][k] = negm[l][k] ? -prod[l][k] : prod[l][k];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Term register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_valid;
    assign o_terms = r_terms;

endmodule

>>> hdl/qalu_sum_stage.sv
module qalu_sum_stage import qalu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_terms i_terms,
    output logic   o_ready,
    output logic   o_valid,
    input  logic   i_ready,
    output t_out   o_data
);

    typedef struct packed {
        logic        ovf;
        logic [63:0] val;
    } t_sat;

    logic signed [ACC_BITS-1:0] acc  [LANES];
    logic signed [ACC_BITS-1:0] shv  [LANES];
    t_sat                       sat  [LANES];
    t_out                       n_out;
    t_out                       r_out;
    logic                       r_valid;
    logic                       load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // Clamp to WORD_BITS signed, result sign-extended to 64 bits
    function automatic t_sat saturate(input logic signed [ACC_BITS-1:0] v);
        t_sat        r;
        logic [63:0] maxv;
        maxv  = (64'd1 << (WORD_BITS - 1)) - 64'd1;
        r.ovf = !((&v[ACC_BITS-1:WORD_BITS-1]) || !(|v[ACC_BITS-1:WORD_BITS-1]));
        if (!r.ovf) begin
            r.val = v[63:0];
        end else if (v[ACC_BITS-1]) begin
            r.val = ~maxv;
        end else begin
            r.val = maxv;
        end
        return r;
    endfunction

    // Four-term sum, fraction shift for multiply, scale and dot, and clamp per lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            acc[l] = ACC_BITS'(i_terms.term[l][0]) + ACC_BITS'(i_terms.term[l][1])
                   + ACC_BITS'(i_terms.term[l][2]) + ACC_BITS'(i_terms.term[l][3]);
            shv[l] = i_terms.scaled ? (acc[l] >>> FRACTION_BITS) : acc[l];
            sat[l] = saturate(shv[l]);
        end
    end

    // Route lanes: dot result leaves on the scalar port
    always_comb begin
        n_out.overflow = sat[LANE_X].ovf | sat[LANE_Y].ovf | sat[LANE_Z].ovf
                       | sat[LANE_W].ovf;
        if (i_terms.op == OP_DOT) begin
            n_out.r_x        = '0;
            n_out.r_y        = '0;
            n_out.r_z        = '0;
            n_out.r_w        = '0;
            n_out.scalar_out = sat[LANE_W].val[FIELD_BITS-1:0];
        end else begin
            n_out.r_x        = sat[LANE_X].val[FIELD_BITS-1:0];
            n_out.r_y        = sat[LANE_Y].val[FIELD_BITS-1:0];
            n_out.r_z        = sat[LANE_Z].val[FIELD_BITS-1:0];
            n_out.r_w        = sat[LANE_W].val[FIELD_BITS-1:0];
            n_out.scalar_out = '0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

>>> hdl/quaternion_alu.sv
// Pipeline: input, product and result registers, in that order.
// Throughput: one item per cycle while i_out_ready holds; the 16-multiplier array and the
// four-term adder each take one pipeline stage.
// Reset: synchronous, active low; clears all stage valid flags, the pipeline comes up empty
// and ready.
module quaternion_alu import qalu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic   r_in_valid;
    t_in    r_in;
    logic   mul_ready;
    logic   mul_valid;
    t_terms mul_terms;
    logic   sum_ready;

    // Input register
    assign o_in_ready = !r_in_valid || mul_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Multiply stage
    qalu_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_data  (r_in),
        .o_ready (mul_ready),
        .o_valid (mul_valid),
        .i_ready (sum_ready),
        .o_terms (mul_terms)
    );

    // Sum, shift and clamp stage
    qalu_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .i_terms (mul_terms),
        .o_ready (sum_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // An empty result register never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty pipeline");

    // A term item moving on must show up as a result
    a_term_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_valid && sum_ready |=> o_out_valid)
        else $error("term item lost between stages");

    // Only a dot result carries a scalar, and then the quaternion is zero
    a_dot_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.scalar_out != '0) |->
            (o_out_data.r_x == '0) && (o_out_data.r_y == '0)
            && (o_out_data.r_z == '0) && (o_out_data.r_w == '0))
        else $error("scalar and quaternion result both nonzero");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid && !mul_valid)
        else $error("pipeline not empty after reset");

endmodule
